// ===== hw/rtl/pidfd_pkg.sv =====
// Shared types, codes and reset constants of the filtered-derivative PID step.
package pidfd_pkg;

	// Port widths fixed by the register map and the item fields
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FIELD_W    = 32;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P          = 3'd0,
		REG_SETPOINT_WEIGHT = 3'd1,
		REG_INTEGRAL_TIME   = 3'd2,
		REG_DERIVATIVE_TIME = 3'd3,
		REG_SAMPLE_PERIOD   = 3'd4,
		REG_FILTER_FACTOR   = 3'd5,
		REG_TARGET          = 3'd6,
		REG_OUTPUT_BIAS     = 3'd7
	} cfg_reg_t;

	// Register reset values in Q16.16, before saturation to the data width
	localparam logic signed [32:0] RST_GAIN_P          = -33'sd80478;
	localparam logic signed [32:0] RST_SETPOINT_WEIGHT = 33'sd65536;
	localparam logic signed [32:0] RST_INTEGRAL_TIME   = 33'sd5325455;
	localparam logic signed [32:0] RST_DERIVATIVE_TIME = 33'sd1277952;
	localparam logic signed [32:0] RST_SAMPLE_PERIOD   = 33'sd65536;
	localparam logic signed [32:0] RST_FILTER_FACTOR   = 33'sd655;
	localparam logic signed [32:0] RST_TARGET          = 33'sd7864320;
	localparam logic signed [32:0] RST_OUTPUT_BIAS     = 33'sd3160985;
	// Integer part of the previous-sample reset value (120.0)
	localparam logic signed [32:0] RST_PREV_INT        = 33'sd120;

	// Sequencer states of the top level
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_BUSY,
		ST_SUM
	} seq_state_t;

	// Operations run through the shared multiply/divide unit, in order
	typedef enum logic [3:0] {
		OP_BT,  // setpoint_weight * target
		OP_P,   // gain_p * weighted error
		OP_A,   // filter_factor * derivative_time
		OP_D,   // a / (a + sample_period)
		OP_M1,  // d * prev_deriv
		OP_M2,  // d * sample difference
		OP_KN,  // sample_period * gain_p
		OP_K,   // kn / integral_time
		OP_M3   // k * error
	} op_t;

	// States of the multiply/divide unit
	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_ROUND,
		MD_PACK
	} md_state_t;

	// Request and response between sequencer and multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} md_rsp_t;

endpackage

// ===== hw/rtl/pidfd_muldiv.sv =====
// Shared iterative fixed-point multiply (16 bits a cycle) and divide (one bit a cycle) unit.
module pidfd_muldiv import pidfd_pkg::*; #(
	parameter int DW   = 32,
	parameter int FRAC = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  md_req_t              req,
	input  logic signed [DW-1:0] opa,
	input  logic signed [DW-1:0] opb,
	output md_rsp_t              rsp,
	output logic signed [DW-1:0] res
);

	localparam int CH  = 16;
	localparam int NCH = (DW + CH - 1) / CH;
	localparam int BW  = NCH * CH;
	localparam int QW  = DW + FRAC;
	localparam int PW  = DW + BW;
	localparam int AW  = (PW > QW) ? PW : QW;
	localparam int CNW = $clog2(QW + 1);

	localparam logic [CNW-1:0] CNT_DIV = CNW'(QW);
	localparam logic [CNW-1:0] CNT_MUL = CNW'(NCH);
	localparam logic [CNW-1:0] CNT_ONE = CNW'(1);
	localparam logic [AW-1:0]  RND     = {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic [AW-1:0]  LIM_POS = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [AW-1:0]  LIM_NEG = LIM_POS + AW'(1);

	md_state_t             state_q, state_d;
	logic                  is_div_q, neg_q, done_q, sat_q;
	logic [DW-1:0]         mag_q, rem_q;
	logic [BW-1:0]         opb_q;
	logic [AW-1:0]         acc_q;
	logic [CNW-1:0]        cnt_q;
	logic signed [DW-1:0]  res_q;

	logic [DW-1:0]         abs_a, abs_b;
	logic [CH-1:0]         chunk;
	logic [DW+CH-1:0]      pp;
	logic [AW-1:0]         mul_next;
	logic [DW:0]           rem_sh;
	logic                  ge;
	logic [DW-1:0]         rem_next;
	logic [AW-1:0]         mag_w, lim_w;
	logic                  over;
	logic [DW-1:0]         res_mag;
	logic signed [DW-1:0]  res_next;

	assign abs_a = opa[DW-1] ? $unsigned(-opa) : $unsigned(opa);
	assign abs_b = opb[DW-1] ? $unsigned(-opb) : $unsigned(opb);

	// Multiply step: most significant chunk of the multiplier first
	always_comb begin
		chunk    = opb_q[BW-1 -: CH];
		pp       = mag_q * chunk;
		mul_next = (acc_q << CH) + AW'(pp);
	end

	// Restoring divide step on the numerator held in the low QW bits of acc
	always_comb begin
		rem_sh   = {rem_q, acc_q[QW-1]};
		ge       = rem_sh >= {1'b0, mag_q};
		rem_next = ge ? DW'(rem_sh - {1'b0, mag_q}) : rem_sh[DW-1:0];
	end

	// Pack: saturate the magnitude to the signed range, then apply the sign
	always_comb begin
		mag_w    = is_div_q ? AW'(acc_q[QW-1:0]) : (acc_q >> FRAC);
		lim_w    = neg_q ? LIM_NEG : LIM_POS;
		over     = mag_w > lim_w;
		res_mag  = over ? lim_w[DW-1:0] : mag_w[DW-1:0];
		res_next = neg_q ? -$signed(res_mag) : $signed(res_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == MD_PACK);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: begin
				if (req.start) state_d = MD_RUN;
			end
			MD_RUN: begin
				if (cnt_q == CNT_ONE) state_d = is_div_q ? MD_PACK : MD_ROUND;
			end
			MD_ROUND: state_d = MD_PACK;
			MD_PACK:  state_d = MD_IDLE;
			default:  state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					is_div_q <= req.is_div;
					neg_q    <= opa[DW-1] ^ opb[DW-1];
					rem_q    <= '0;
					opb_q    <= BW'(abs_b);
					if (req.is_div) begin
						cnt_q <= CNT_DIV;
						mag_q <= abs_b;
						acc_q <= AW'(abs_a) << FRAC;
					end else begin
						cnt_q <= CNT_MUL;
						mag_q <= abs_a;
						acc_q <= '0;
					end
				end
			end
			MD_RUN: begin
				cnt_q <= cnt_q - CNT_ONE;
				if (is_div_q) begin
					rem_q <= rem_next;
					acc_q <= {acc_q[AW-2:0], ge};
				end else begin
					acc_q <= mul_next;
					opb_q <= opb_q << CH;
				end
			end
			MD_ROUND: acc_q <= acc_q + RND;
			MD_PACK: begin
				res_q <= res_next;
				sat_q <= over;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign res      = res_q;

endmodule

// ===== hw/rtl/pid_filtered_derivative_step.sv =====
// Top level: PID step with setpoint weighting and a filtered derivative, signed fixed point.
// One sample word at a time: a new one is taken only in the idle state, after the integral
//   work of the last one; the result word can hold the sequencer while the previous one waits.
// All products and quotients go through the one multiply/divide unit: 16 multiplier bits or
//   one quotient bit a cycle.
// Reset (async, active low): registers to defaults, previous sample 120.0, previous derivative and integral zero.
module pid_filtered_derivative_step import pidfd_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic signed [FIELD_W-1:0] sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic signed [FIELD_W-1:0] drive,
	output logic                  clipped
);

	localparam int DW  = DATA_WIDTH;
	localparam int IW  = (DW > 33) ? DW : 33;        // width to saturate 33-bit inputs in
	localparam int SW  = DW + 2;                     // four-term output sum
	localparam int DRV = (DW < FIELD_W) ? DW : FIELD_W;
	localparam int XW  = (SW > FIELD_W) ? SW : FIELD_W;

	localparam logic signed [IW-1:0] IN_MAX = {{(IW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [IW-1:0] IN_MIN = ~IN_MAX;
	localparam logic signed [SW-1:0] D_MAX  = {{(SW-DRV+1){1'b0}}, {(DRV-1){1'b1}}};
	localparam logic signed [SW-1:0] D_MIN  = ~D_MAX;
	localparam logic signed [DW-1:0] V_MAX  = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] V_MIN  = ~V_MAX;
	localparam logic signed [32:0]   PREV_RST = RST_PREV_INT <<< FRAC_BITS;

	// Clamp a 33-bit register or sample value into the data range
	function automatic logic signed [DW-1:0] sat_in(input logic signed [32:0] v);
		logic signed [IW-1:0] w;
		w = IW'(v);
		if (w > IN_MAX) return IN_MAX[DW-1:0];
		if (w < IN_MIN) return IN_MIN[DW-1:0];
		return w[DW-1:0];
	endfunction

	// Configuration registers, held saturated to the data range
	logic signed [DW-1:0] gain_p_q, beta_q, ti_q, td_q, ts_q, ff_q, target_q, bias_q;
	// Controller state carried between samples
	logic signed [DW-1:0] prev_sample_q, prev_deriv_q, integ_now_q, integ_next_q;
	// Working registers of one step
	logic signed [DW-1:0] s_q, e_q, p_q, a_q, den_q, coef_q, m1_q, dd_q;
	logic                 clip_q;
	// Output register
	logic                 result_valid_q, clipped_q;
	logic signed [FIELD_W-1:0] drive_q;

	seq_state_t state_q, state_d;
	op_t        op_q, op_d;
	logic       accept, capture, sum_fire;

	md_req_t              md_req;
	md_rsp_t              md_rsp;
	logic signed [DW-1:0] md_a, md_b, md_res;

	logic signed [DW-1:0] add_x, add_y, add_sat;
	logic                 add_sub, add_hit;
	logic signed [DW:0]   add_w;
	logic                 den_nz, ti_nz, clip_hit;

	logic signed [SW-1:0] u_w, u_c;
	logic signed [XW-1:0] u_x;
	logic                 u_hit;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign den_nz       = (den_q != '0);
	assign ti_nz        = (ti_q != '0);

	pidfd_muldiv #(
		.DW   (DW),
		.FRAC (FRAC_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.opa    (md_a),
		.opb    (md_b),
		.rsp    (md_rsp),
		.res    (md_res)
	);

	// Sequencer: issue each operation, wait for the unit, capture, then move on.
	// The result word is written between the derivative and the integral work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_BT;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		md_req.start  = 1'b0;
		md_req.is_div = (op_q == OP_D) || (op_q == OP_K);
		capture       = 1'b0;
		sum_fire      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = ST_ISSUE;
					op_d    = OP_BT;
				end
			end
			ST_ISSUE: begin
				md_req.start = 1'b1;
				state_d      = ST_BUSY;
			end
			ST_BUSY: begin
				if (md_rsp.done) begin
					capture = 1'b1;
					state_d = ST_ISSUE;
					case (op_q)
						OP_BT:   op_d = OP_P;
						OP_P:    op_d = OP_A;
						OP_A:    op_d = OP_D;
						OP_D:    op_d = OP_M1;
						OP_M1:   op_d = OP_M2;
						OP_M2:   state_d = ST_SUM;
						OP_KN:   op_d = OP_K;
						OP_K:    op_d = OP_M3;
						OP_M3:   state_d = ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SUM: begin
				// hold here while the previous word still waits downstream
				if (!result_valid_q || result_ready) begin
					sum_fire = 1'b1;
					op_d     = OP_KN;
					state_d  = ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand select for the shared unit
	always_comb begin
		case (op_q)
			OP_BT:   begin md_a = beta_q;   md_b = target_q;     end
			OP_P:    begin md_a = gain_p_q; md_b = e_q;          end
			OP_A:    begin md_a = ff_q;     md_b = td_q;         end
			OP_D:    begin md_a = a_q;      md_b = den_q;        end
			OP_M1:   begin md_a = coef_q;   md_b = prev_deriv_q; end
			OP_M2:   begin md_a = coef_q;   md_b = e_q;          end
			OP_KN:   begin md_a = ts_q;     md_b = gain_p_q;     end
			OP_K:    begin md_a = a_q;      md_b = ti_q;         end
			OP_M3:   begin md_a = coef_q;   md_b = e_q;          end
			default: begin md_a = beta_q;   md_b = target_q;     end
		endcase
	end

	// One saturating add/subtract, shared by every capture that needs one
	always_comb begin
		add_sub = 1'b1;
		case (op_q)
			OP_BT:   begin add_x = md_res;      add_y = s_q;           end
			OP_A:    begin add_x = md_res;      add_y = ts_q;          add_sub = 1'b0; end
			OP_M1:   begin add_x = s_q;         add_y = prev_sample_q; end
			OP_M2:   begin add_x = m1_q;        add_y = md_res;        end
			OP_K:    begin add_x = target_q;    add_y = s_q;           end
			OP_M3:   begin add_x = integ_now_q; add_y = md_res;        add_sub = 1'b0; end
			default: begin add_x = md_res;      add_y = '0;            add_sub = 1'b0; end
		endcase
		add_w   = add_sub ? ({add_x[DW-1], add_x} - {add_y[DW-1], add_y})
		                  : ({add_x[DW-1], add_x} + {add_y[DW-1], add_y});
		add_hit = add_w[DW] != add_w[DW-1];
		add_sat = add_hit ? (add_w[DW] ? V_MIN : V_MAX) : add_w[DW-1:0];
	end

	// Saturation seen on the path to drive; integral work does not count
	always_comb begin
		case (op_q)
			OP_BT:   clip_hit = md_rsp.sat | add_hit;
			OP_P:    clip_hit = md_rsp.sat;
			OP_A:    clip_hit = md_rsp.sat | add_hit;
			OP_D:    clip_hit = md_rsp.sat & den_nz;
			OP_M1:   clip_hit = md_rsp.sat | add_hit;
			OP_M2:   clip_hit = md_rsp.sat | add_hit;
			default: clip_hit = 1'b0;
		endcase
	end

	// drive = bias + P + integ_now + D, clamped to the drive range
	always_comb begin
		u_w   = SW'(bias_q) + SW'(p_q) + SW'(integ_now_q) + SW'(dd_q);
		u_hit = (u_w > D_MAX) || (u_w < D_MIN);
		if (u_w > D_MAX)      u_c = D_MAX;
		else if (u_w < D_MIN) u_c = D_MIN;
		else                  u_c = u_w;
		u_x = XW'(u_c);
	end

	// Working registers: capture each unit result with its follow-up add
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= sat_in({sample[FIELD_W-1], sample});
			clip_q <= 1'b0;
		end
		if (capture) begin
			clip_q <= clip_q | clip_hit;
			case (op_q)
				OP_BT: e_q <= add_sat;
				OP_P:  p_q <= md_res;
				OP_A: begin
					a_q   <= md_res;
					den_q <= add_sat;
				end
				// zero denominator: drop the quotient, derivative weight is zero
				OP_D:  coef_q <= den_nz ? md_res : '0;
				OP_M1: begin
					m1_q <= md_res;
					e_q  <= add_sat;
				end
				OP_M2: dd_q <= add_sat;
				// a_q is free after the divide, so it holds sample_period * gain_p
				OP_KN: a_q <= md_res;
				// zero integral time: hold the integral still
				OP_K: begin
					coef_q <= ti_nz ? md_res : '0;
					e_q    <= add_sat;
				end
				default: ;
			endcase
		end
		if (sum_fire) begin
			drive_q   <= u_x[FIELD_W-1:0];
			clipped_q <= clip_q | u_hit;
		end
	end

	// Configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= sat_in(RST_GAIN_P);
			beta_q         <= sat_in(RST_SETPOINT_WEIGHT);
			ti_q           <= sat_in(RST_INTEGRAL_TIME);
			td_q           <= sat_in(RST_DERIVATIVE_TIME);
			ts_q           <= sat_in(RST_SAMPLE_PERIOD);
			ff_q           <= sat_in(RST_FILTER_FACTOR);
			target_q       <= sat_in(RST_TARGET);
			bias_q         <= sat_in(RST_OUTPUT_BIAS);
			prev_sample_q  <= sat_in(PREV_RST);
			prev_deriv_q   <= '0;
			integ_now_q    <= '0;
			integ_next_q   <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_idx))
					REG_GAIN_P:          gain_p_q <= sat_in({cfg_wdata[31], cfg_wdata});
					REG_SETPOINT_WEIGHT: beta_q   <= sat_in({15'd0, cfg_wdata[17:0]});
					REG_INTEGRAL_TIME:   ti_q     <= sat_in({2'd0, cfg_wdata[30:0]});
					REG_DERIVATIVE_TIME: td_q     <= sat_in({2'd0, cfg_wdata[30:0]});
					REG_SAMPLE_PERIOD:   ts_q     <= sat_in({2'd0, cfg_wdata[30:0]});
					REG_FILTER_FACTOR:   ff_q     <= sat_in({16'd0, cfg_wdata[16:0]});
					REG_TARGET:          target_q <= sat_in({cfg_wdata[31], cfg_wdata});
					REG_OUTPUT_BIAS:     bias_q   <= sat_in({cfg_wdata[31], cfg_wdata});
					default: ;
				endcase
			end
			if (result_valid_q && result_ready) result_valid_q <= 1'b0;
			if (sum_fire) begin
				// advance the two-stage integral and keep this sample's values
				result_valid_q <= 1'b1;
				prev_deriv_q   <= dd_q;
				prev_sample_q  <= s_q;
				integ_now_q    <= integ_next_q;
			end
			// integ_now already holds the old integ_next here
			if (capture && (op_q == OP_M3)) integ_next_q <= add_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign drive        = drive_q;
	assign clipped      = clipped_q;

endmodule

// ===== sim/pid_filtered_derivative_step_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the filtered-derivative PID step: random and directed sample words.
module pid_filtered_derivative_step_tb
	import pidfd_pkg::*;
();

	// Q16.16 range at the default data width
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -Q_MAX - 1;
	localparam int     FRAC  = 16;
	localparam longint ONE   = 64'sd1 << FRAC;
	// Cycles with no word moving on either channel before the run is called dead
	localparam int     QUIET_LIMIT = 5000;
	// Cycles to let pass after the last drive word
	localparam int     SETTLE_CYCLES = 100;
	// Length of each deliberate hold-off on the drive side
	localparam int     HOLD_CYCLES = 700;

	typedef enum {SET_RESET, SET_PLANT, SET_WILD, SET_HIGH, SET_LOW} set_kind_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               clipped;
	} drive_word_t;

	// Tracks the controller state, predicts each drive word and checks the block's words
	class drive_book;
		longint gain, weight, ti_q, td_q, ts_q, alpha, setp, bias;
		longint last_s, last_d, integ_now, integ_next;
		bit hit;
		drive_word_t pending[$];
		int n_bad, n_checked, n_clipped;

		function new();
			gain       = longint'(RST_GAIN_P);
			weight     = longint'(RST_SETPOINT_WEIGHT);
			ti_q       = longint'(RST_INTEGRAL_TIME);
			td_q       = longint'(RST_DERIVATIVE_TIME);
			ts_q       = longint'(RST_SAMPLE_PERIOD);
			alpha      = longint'(RST_FILTER_FACTOR);
			setp       = longint'(RST_TARGET);
			bias       = longint'(RST_OUTPUT_BIAS);
			last_s     = longint'(RST_PREV_INT) * ONE;
			last_d     = 0;
			integ_now  = 0;
			integ_next = 0;
		endfunction

		function longint clamp(longint x);
			if (x > Q_MAX) begin
				hit = 1'b1;
				return Q_MAX;
			end
			if (x < Q_MIN) begin
				hit = 1'b1;
				return Q_MIN;
			end
			return x;
		endfunction

		function logic [127:0] mag(longint x);
			logic signed [127:0] t;
			t = x;
			if (t < 0)
				t = -t;
			return t;
		endfunction

		// Signed value from sign and magnitude, clamped to the range of its sign
		function longint from_mag(bit neg, logic [127:0] m);
			logic [127:0] lim;
			lim = neg ? 128'(Q_MAX) + 128'd1 : 128'(Q_MAX);
			if (m > lim) begin
				hit = 1'b1;
				m = lim;
			end
			return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
		endfunction

		// Product rounded to nearest, halves away from zero
		function longint mul_q(longint a, longint b);
			logic [127:0] pr;
			pr = mag(a) * mag(b) + (128'd1 << (FRAC - 1));
			return from_mag((a < 0) != (b < 0), pr >> FRAC);
		endfunction

		// Quotient truncated toward zero; divisor never zero here
		function longint div_q(longint n, longint d);
			return from_mag((n < 0) != (d < 0), (mag(n) << FRAC) / mag(d));
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				REG_GAIN_P:          gain   = longint'($signed(v));
				REG_SETPOINT_WEIGHT: weight = longint'(v[17:0]);
				REG_INTEGRAL_TIME:   ti_q   = longint'(v[30:0]);
				REG_DERIVATIVE_TIME: td_q   = longint'(v[30:0]);
				REG_SAMPLE_PERIOD:   ts_q   = longint'(v[30:0]);
				REG_FILTER_FACTOR:   alpha  = longint'(v[16:0]);
				REG_TARGET:          setp   = longint'($signed(v));
				REG_OUTPUT_BIAS:     bias   = longint'($signed(v));
				default: ;
			endcase
		endfunction

		// Work out the drive word for an accepted sample, then advance the state
		function void note_sample(logic signed [31:0] smp);
			longint s, p, a, den, d, dd, u, k;
			drive_word_t w;
			s = longint'(smp);
			hit = 1'b0;
			p = mul_q(gain, clamp(mul_q(weight, setp) - s));
			a = mul_q(alpha, td_q);
			den = clamp(a + ts_q);
			d = 0;
			if (den != 0)
				d = div_q(a, den);
			dd = clamp(mul_q(d, last_d) - mul_q(d, clamp(s - last_s)));
			u = bias + p + integ_now + dd;
			if (u > Q_MAX) begin
				u = Q_MAX;
				hit = 1'b1;
			end
			if (u < Q_MIN) begin
				u = Q_MIN;
				hit = 1'b1;
			end
			w.drive = u[31:0];
			w.clipped = hit;
			pending.push_back(w);
			// Integral runs one stage behind; its clamping does not reach the flag
			last_d = dd;
			last_s = s;
			integ_now = integ_next;
			k = 0;
			if (ti_q != 0)
				k = div_q(mul_q(ts_q, gain), ti_q);
			integ_next = clamp(integ_now + mul_q(k, clamp(setp - s)));
		endfunction

		function void check_drive(logic signed [31:0] got_drive, logic got_clip);
			drive_word_t want;
			n_checked++;
			if (pending.size() == 0) begin
				$error("drive word with no sample waiting: drive %0d clipped %0b",
					got_drive, got_clip);
				n_bad++;
				return;
			end
			want = pending.pop_front();
			if (want.clipped)
				n_clipped++;
			if (got_drive !== want.drive) begin
				$error("drive: expected %0d, got %0d", want.drive, got_drive);
				n_bad++;
			end
			if (got_clip !== want.clipped) begin
				$error("clipped: expected %0b, got %0b", want.clipped, got_clip);
				n_bad++;
			end
		endfunction
	endclass

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         cfg_wen      = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_idx      = '0;
	logic [CFG_DATA_W-1:0]        cfg_wdata    = '0;
	logic                         sample_valid = 1'b0;
	logic                         sample_ready;
	logic signed [FIELD_W-1:0]    sample       = '0;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic signed [FIELD_W-1:0]    drive;
	logic                         clipped;

	drive_book book = new();

	int     src_idle_pct  = 17;
	int     sink_idle_pct = 48;
	int     n_sent        = 0;
	int     n_settings    = 1;
	longint walk          = 64'sd7864320;

	// Directed sample words: rest value, zero, both ends, a repeat, minus one and one, alternating bits, steps near rest
	logic signed [31:0] corner_samples [12] = '{
		32'sd7864320, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
		32'sh7FFFFFFF, -32'sd1, 32'sd1, 32'sh55555555, 32'shAAAAAAAA,
		32'sd7962624, 32'sd7749632
	};

	// Random phases: register setting and number of sample words in each
	set_kind_t block_kind [9] = '{SET_RESET, SET_PLANT, SET_WILD, SET_HIGH, SET_PLANT,
		SET_LOW, SET_PLANT, SET_WILD, SET_PLANT};
	int        block_len  [9] = '{240, 260, 220, 120, 260, 120, 260, 240, 160};

	pid_filtered_derivative_step u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drive        (drive),
		.clipped      (clipped)
	);

	always #10 clk = ~clk;

	// Offer one sample word from a falling edge; return at the falling edge after acceptance.
	// Idle gaps lower valid only before the word is offered, never while it waits.
	task automatic offer_sample(logic signed [31:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= v;
		do
			@(posedge clk);
		while (!sample_ready);
		book.note_sample(v);
		n_sent++;
		@(negedge clk);
	endtask

	// Stop offering and hold until every predicted drive word has come back and the
	// block has finished its integral work and is ready again
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (book.pending.size() != 0 || !sample_ready)
			@(negedge clk);
	endtask

	// One register write per cycle; the caller drops the write enable after the last
	task automatic put_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		book.write_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic load_config(set_kind_t kind);
		logic [31:0] v [8];
		cfg_reg_t r;
		case (kind)
			SET_RESET: begin
				v[REG_GAIN_P]          = RST_GAIN_P[31:0];
				v[REG_SETPOINT_WEIGHT] = RST_SETPOINT_WEIGHT[31:0];
				v[REG_INTEGRAL_TIME]   = RST_INTEGRAL_TIME[31:0];
				v[REG_DERIVATIVE_TIME] = RST_DERIVATIVE_TIME[31:0];
				v[REG_SAMPLE_PERIOD]   = RST_SAMPLE_PERIOD[31:0];
				v[REG_FILTER_FACTOR]   = RST_FILTER_FACTOR[31:0];
				v[REG_TARGET]          = RST_TARGET[31:0];
				v[REG_OUTPUT_BIAS]     = RST_OUTPUT_BIAS[31:0];
			end
			// Values a real loop would use: gains of a few units, times up to minutes
			SET_PLANT: begin
				v[REG_GAIN_P]          = $urandom_range(0, 8 * 65536) - 4 * 65536;
				v[REG_SETPOINT_WEIGHT] = $urandom_range(0, 2 * 65536);
				v[REG_INTEGRAL_TIME]   = $urandom_range(65536, 200 * 65536);
				v[REG_DERIVATIVE_TIME] = $urandom_range(0, 60 * 65536);
				v[REG_SAMPLE_PERIOD]   = $urandom_range(6554, 4 * 65536);
				v[REG_FILTER_FACTOR]   = $urandom_range(0, 65536);
				v[REG_TARGET]          = $urandom_range(0, 400 * 65536) - 200 * 65536;
				v[REG_OUTPUT_BIAS]     = $urandom_range(0, 200 * 65536) - 100 * 65536;
			end
			// Whole 32-bit words; the block drops bits above each register's width
			SET_WILD: begin
				foreach (v[i])
					v[i] = $urandom();
			end
			SET_HIGH: begin
				v[REG_GAIN_P]          = 32'h7FFF_FFFF;
				v[REG_SETPOINT_WEIGHT] = 32'hFFFF_FFFF;
				v[REG_INTEGRAL_TIME]   = 32'hFFFF_FFFF;
				v[REG_DERIVATIVE_TIME] = 32'hFFFF_FFFF;
				v[REG_SAMPLE_PERIOD]   = 32'hFFFF_FFFF;
				v[REG_FILTER_FACTOR]   = 32'hFFFF_FFFF;
				v[REG_TARGET]          = 32'h7FFF_FFFF;
				v[REG_OUTPUT_BIAS]     = 32'h7FFF_FFFF;
			end
			// Zero times and zero filter: integral frozen and derivative gain zero
			default: begin
				v[REG_GAIN_P]          = 32'h8000_0000;
				v[REG_SETPOINT_WEIGHT] = 32'h0;
				v[REG_INTEGRAL_TIME]   = 32'h0;
				v[REG_DERIVATIVE_TIME] = 32'h0;
				v[REG_SAMPLE_PERIOD]   = 32'h0;
				v[REG_FILTER_FACTOR]   = 32'h0;
				v[REG_TARGET]          = 32'h8000_0000;
				v[REG_OUTPUT_BIAS]     = 32'h8000_0000;
			end
		endcase
		r = r.first();
		repeat (r.num()) begin
			put_reg(r, v[r]);
			r = r.next();
		end
		cfg_wen <= 1'b0;
		n_settings++;
	endtask

	// Plant-like samples wander around the setpoint; the rest are range ends and noise
	function automatic logic signed [31:0] pick_sample(bit plant);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4) begin
			case ($urandom_range(3))
				0:       walk = Q_MAX;
				1:       walk = Q_MIN;
				2:       walk = 0;
				default: walk = -1;
			endcase
		end else if (r < (plant ? 12 : 60)) begin
			walk = longint'($signed($urandom()));
		end else if (r >= 96) begin
			walk = book.setp + longint'($urandom_range(0, 40 * 65536)) - 20 * ONE;
		end else begin
			walk = walk + longint'($urandom_range(0, 4 * 65536)) - 2 * ONE;
		end
		if (walk > Q_MAX)
			walk = Q_MAX;
		if (walk < Q_MIN)
			walk = Q_MIN;
		return walk[31:0];
	endfunction

	// Drive side: random stalls, plus two long hold-offs so the block backs up
	// and has to stall its sample input
	initial begin : drive_sink
		int hold_left;
		int holds_done;
		hold_left  = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done < 2 &&
				book.n_checked >= (holds_done == 0 ? 400 : 1500)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Check every accepted drive word; end the run if the block goes quiet
	initial begin : monitor
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				book.check_drive(drive, clipped);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$error("no word moved for %0d cycles", QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset setting
		foreach (corner_samples[i])
			offer_sample(corner_samples[i]);

		// Zero integral time: the integral must stop advancing
		drain_results();
		put_reg(REG_INTEGRAL_TIME, 32'h0);
		cfg_wen <= 1'b0;
		n_settings++;
		offer_sample(32'(100 * ONE));
		offer_sample(32'(140 * ONE));
		offer_sample(32'(120 * ONE));

		// Filter and period both zero: derivative coefficient falls to zero
		drain_results();
		put_reg(REG_INTEGRAL_TIME, RST_INTEGRAL_TIME[31:0]);
		put_reg(REG_FILTER_FACTOR, 32'h0);
		put_reg(REG_SAMPLE_PERIOD, 32'h0);
		cfg_wen <= 1'b0;
		n_settings++;
		offer_sample(32'(110 * ONE));
		offer_sample(-32'sd5);
		offer_sample(32'sh7FFFFFFF);

		// Largest filter and derivative time with the smallest period: coefficient near one
		drain_results();
		put_reg(REG_FILTER_FACTOR, 32'hFFFF_FFFF);
		put_reg(REG_DERIVATIVE_TIME, 32'hFFFF_FFFF);
		put_reg(REG_SAMPLE_PERIOD, 32'h1);
		cfg_wen <= 1'b0;
		n_settings++;
		offer_sample(32'(121 * ONE));
		offer_sample(32'(119 * ONE));
		offer_sample(32'sh80000000);

		// Random phases; the idle split changes after the third and sixth
		for (int b = 0; b < 9; b++) begin
			if (b == 3) begin
				src_idle_pct  = 48;
				sink_idle_pct = 17;
			end
			if (b == 6) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			drain_results();
			load_config(block_kind[b]);
			repeat (block_len[b])
				offer_sample(pick_sample(block_kind[b] == SET_RESET ||
					block_kind[b] == SET_PLANT));
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.pending.size() != 0)
			$error("%0d drive words never arrived", book.pending.size());
		$display("covered %0d sample words over %0d register settings: reset, plant-like,",
			n_sent, n_settings);
		$display("random, all-high and all-low; %0d drive words checked, %0d clipped, %0d bad",
			book.n_checked, book.n_clipped, book.n_bad);
		if (book.n_bad == 0 && book.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== pid_filtered_derivative_step.f =====
hw/rtl/pidfd_pkg.sv
hw/rtl/pidfd_muldiv.sv
hw/rtl/pid_filtered_derivative_step.sv
sim/pid_filtered_derivative_step_tb.sv
